@@ hw/rtl/gboc_pkg.sv @@
package gboc_pkg;

    // configuration port geometry
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 19;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_ARCH_MAJOR   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ARCH_MINOR   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_WARP_WIDTH   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_THREADS_SM   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_REGS_SM      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SHARED_SM    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SHARED_OPTIN = 3'd6;

    // register reset values
    localparam logic [3:0]  RST_ARCH_MAJOR   = 4'd8;
    localparam logic [3:0]  RST_ARCH_MINOR   = 4'd0;
    localparam logic [6:0]  RST_WARP_WIDTH   = 7'd32;
    localparam logic [12:0] RST_THREADS_SM   = 13'd2048;
    localparam logic [16:0] RST_REGS_SM      = 17'd65536;
    localparam logic [18:0] RST_SHARED_SM    = 19'd167936;
    localparam logic [18:0] RST_SHARED_OPTIN = 19'd166912;

    // resident block caps and architecture thresholds
    localparam logic [5:0] CAP_HI = 6'd32;
    localparam logic [5:0] CAP_LO = 6'd16;
    localparam logic [3:0] MAJOR_NEW   = 4'd9;
    localparam logic [3:0] MAJOR_MID   = 4'd8;
    localparam logic [3:0] MAJOR_OLD   = 4'd7;
    localparam logic [3:0] MINOR_SPLIT = 4'd6;

    // 100 percent in Q8.8
    localparam logic [20:0] OCC_SCALE = 21'd25600;
    localparam logic [15:0] OCC_SAT   = 16'hFFFF;

    typedef struct packed {
        logic       empty;
        logic       ovf;
        logic       smem_zero;
        logic       treg_zero;
        logic [5:0] cap;
    } flags_t;

    // sideband across the first divider group
    typedef struct packed {
        flags_t      f;
        logic [62:0] grid;
    } sba_t;

    // sideband across the warp limit divider
    typedef struct packed {
        flags_t      f;
        logic [62:0] grid;
        logic [29:0] wpb;
        logic [12:0] mw;
        logic [18:0] sl_raw;
        logic [16:0] rl_raw;
    } sbb_t;

    // limits after the minimum stage
    typedef struct packed {
        flags_t      f;
        logic [62:0] grid;
        logic [29:0] wpb;
        logic [12:0] mw;
        logic [12:0] wl;
        logic [16:0] rl;
        logic [18:0] sl;
        logic [5:0]  blocks;
    } sbm_t;

    // sideband across occupancy and wave dividers
    typedef struct packed {
        flags_t      f;
        logic [12:0] wl;
        logic [16:0] rl;
        logic [18:0] sl;
        logic [5:0]  blocks;
        logic        sat;
    } sbc_t;

    // sideband across the fraction divider
    typedef struct packed {
        sbc_t        c;
        logic [15:0] occ;
        logic [62:0] waves;
    } sbd_t;

endpackage

@@ hw/rtl/gboc_div.sv @@
// Pipelined restoring divider. The caller packs {high, low} into acc_i with
// high < den_i; the register of the last stage then holds {remainder, quotient}.
module gboc_div #(
    parameter int QW     = 8,
    parameter int DW     = 8,
    parameter int STAGES = 2
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [DW+QW-1:0]   acc_i,
    input  logic [DW-1:0]      den_i,
    output logic [QW-1:0]      quo_o,
    output logic [DW-1:0]      rem_o
);

    localparam int AW  = DW + QW;
    localparam int SPS = (QW + STAGES - 1) / STAGES;

    for (genvar s = 0; s < STAGES; s++) begin : g_stg
        logic [AW-1:0] a_in;
        logic [AW-1:0] acc_next;
        logic [DW-1:0] d_in;
        logic [AW-1:0] acc_reg;
        logic [DW-1:0] den_reg;

        if (s == 0) begin : g_first
            assign a_in = acc_i;
            assign d_in = den_i;
        end else begin : g_rest
            assign a_in = g_stg[s-1].acc_reg;
            assign d_in = g_stg[s-1].den_reg;
        end

        // up to SPS shift / compare / subtract steps per stage
        always_comb begin
            logic [DW:0] t;
            t        = '0;
            acc_next = a_in;
            for (int k = 0; k < SPS; k++) begin
                if (s * SPS + k < QW) begin
                    t = acc_next[AW-1:QW-1];
                    if (t >= {1'b0, d_in}) begin
                        t        = t - {1'b0, d_in};
                        acc_next = {t[DW-1:0], acc_next[QW-2:0], 1'b1};
                    end else begin
                        acc_next = {t[DW-1:0], acc_next[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg <= acc_next;
                den_reg <= d_in;
            end
        end
    end

    assign quo_o = g_stg[STAGES-1].acc_reg[QW-1:0];
    assign rem_o = g_stg[STAGES-1].acc_reg[AW-1:QW];

endmodule

@@ hw/rtl/gboc_dly.sv @@
// Sideband delay line that moves in step with the divider stages.
module gboc_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_i,
    output logic [W-1:0] q_o
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d_i;
            for (int i = 1; i < D; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q_o = pipe_reg[D-1];

endmodule

@@ hw/rtl/gpu_block_occupancy_calc.sv @@
// Occupancy calculator: one kernel launch description per beat in, one result
// per beat out. A new launch may enter every cycle while the result beat is not
// held, so sustained rate is one per clock. Each launch passes through multiply
// stages and a chain of pipelined restoring dividers (warps per block,
// then warp limit, then occupancy and waves, then wave fraction). When the
// result beat is held by m_ready low the whole pipeline freezes and s_ready
// drops; nothing is lost or repeated. Configuration writes take effect at once
// and must only be issued while no launch is in flight.
module gpu_block_occupancy_calc (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [gboc_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [gboc_pkg::CFG_DW-1:0] cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [10:0]                 s_block_x,
    input  logic [10:0]                 s_block_y,
    input  logic [6:0]                  s_block_z,
    input  logic [30:0]                 s_grid_x,
    input  logic [15:0]                 s_grid_y,
    input  logic [15:0]                 s_grid_z,
    input  logic [7:0]                  s_thread_registers,
    input  logic [18:0]                 s_static_shared,
    input  logic [18:0]                 s_dynamic_shared,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_valid_res,
    output logic [5:0]                  m_arch_block_cap,
    output logic [12:0]                 m_warp_limit,
    output logic [13:0]                 m_register_limit,
    output logic [18:0]                 m_shared_limit,
    output logic [5:0]                  m_blocks_per_sm,
    output logic [15:0]                 m_occupancy_q8,
    output logic [62:0]                 m_waves_rounded_up,
    output logic [7:0]                  m_wave_fraction_q8
);

    localparam int LAT_A = 8;
    localparam int LAT_B = 4;
    localparam int LAT_C = 8;
    localparam int LAT_D = 2;
    localparam int LAT   = 3 + LAT_A + LAT_B + 4 + LAT_C + LAT_D + 1;

    logic en;
    logic [LAT-1:0] vld_reg;

    // configuration registers
    logic [3:0]  arch_major_reg;
    logic [3:0]  arch_minor_reg;
    logic [6:0]  warp_width_reg;
    logic [12:0] threads_sm_reg;
    logic [16:0] regs_sm_reg;
    logic [18:0] shared_sm_reg;
    logic [18:0] shared_optin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_major_reg   <= gboc_pkg::RST_ARCH_MAJOR;
            arch_minor_reg   <= gboc_pkg::RST_ARCH_MINOR;
            warp_width_reg   <= gboc_pkg::RST_WARP_WIDTH;
            threads_sm_reg   <= gboc_pkg::RST_THREADS_SM;
            regs_sm_reg      <= gboc_pkg::RST_REGS_SM;
            shared_sm_reg    <= gboc_pkg::RST_SHARED_SM;
            shared_optin_reg <= gboc_pkg::RST_SHARED_OPTIN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gboc_pkg::REG_ARCH_MAJOR:   arch_major_reg   <= cfg_wdata[3:0];
                gboc_pkg::REG_ARCH_MINOR:   arch_minor_reg   <= cfg_wdata[3:0];
                gboc_pkg::REG_WARP_WIDTH:   warp_width_reg   <= cfg_wdata[6:0];
                gboc_pkg::REG_THREADS_SM:   threads_sm_reg   <= cfg_wdata[12:0];
                gboc_pkg::REG_REGS_SM:      regs_sm_reg      <= cfg_wdata[16:0];
                gboc_pkg::REG_SHARED_SM:    shared_sm_reg    <= cfg_wdata[18:0];
                gboc_pkg::REG_SHARED_OPTIN: shared_optin_reg <= cfg_wdata[18:0];
                default: ;
            endcase
        end
    end

    // global advance: the output register is empty or being drained
    assign m_valid = vld_reg[LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: first products, shared sum, register granule, block cap
    logic [5:0]  cap_next;
    logic [8:0]  treg_up;
    logic [21:0] bxy_reg;
    logic [6:0]  bz_reg;
    logic [46:0] gxy_reg;
    logic [15:0] gz_reg;
    logic [8:0]  rr1_reg;
    gboc_pkg::flags_t f1_reg;

    always_comb begin
        if (arch_major_reg >= gboc_pkg::MAJOR_NEW) begin
            cap_next = gboc_pkg::CAP_HI;
        end else if (arch_major_reg == gboc_pkg::MAJOR_MID
                     && arch_minor_reg >= gboc_pkg::MINOR_SPLIT) begin
            cap_next = gboc_pkg::CAP_LO;
        end else if (arch_major_reg == gboc_pkg::MAJOR_MID
                     || arch_major_reg == gboc_pkg::MAJOR_OLD) begin
            cap_next = gboc_pkg::CAP_HI;
        end else begin
            cap_next = gboc_pkg::CAP_LO;
        end
        treg_up = 9'(s_thread_registers) + 9'd7;
    end

    // shared sum and opt-in check
    logic [19:0] smem;
    assign smem = 20'(s_static_shared) + 20'(s_dynamic_shared);

    logic [19:0] smem1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            bxy_reg          <= 22'(s_block_x) * 22'(s_block_y);
            bz_reg           <= s_block_z;
            gxy_reg          <= 47'(s_grid_x) * 47'(s_grid_y);
            gz_reg           <= s_grid_z;
            rr1_reg          <= {treg_up[8:3], 3'b000};
            smem1_reg        <= smem;
            f1_reg.empty     <= 1'b0;
            f1_reg.ovf       <= s_dynamic_shared > shared_optin_reg;
            f1_reg.smem_zero <= smem == 20'd0;
            f1_reg.treg_zero <= s_thread_registers == 8'd0;
            f1_reg.cap       <= cap_next;
        end
    end

    // stage 2: thread count and grid size
    logic [28:0] thr2_reg;
    logic [62:0] grid2_reg;
    logic [8:0]  rr2_reg;
    logic [19:0] smem2_reg;
    gboc_pkg::flags_t f2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            thr2_reg  <= 29'(bxy_reg) * 29'(bz_reg);
            grid2_reg <= 63'(gxy_reg) * 63'(gz_reg);
            rr2_reg   <= rr1_reg;
            smem2_reg <= smem1_reg;
            f2_reg    <= f1_reg;
        end
    end

    // stage 3: rounded-up numerator and block register footprint
    logic [37:0] rt;
    logic [29:0] wpbn3_reg;
    logic [17:0] rt3_reg;
    logic [19:0] smem3_reg;
    gboc_pkg::sba_t sba3_reg;

    assign rt = 38'(rr2_reg) * 38'(thr2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            wpbn3_reg <= 30'(thr2_reg) + 30'(warp_width_reg) - 30'd1;
            // anything at or past 2^17 exceeds every register file
            rt3_reg   <= (|rt[37:17]) ? 18'h20000 : rt[17:0];
            smem3_reg <= smem2_reg;
            sba3_reg.f.empty     <= thr2_reg == 29'd0 || warp_width_reg == 7'd0;
            sba3_reg.f.ovf       <= f2_reg.ovf;
            sba3_reg.f.smem_zero <= f2_reg.smem_zero;
            sba3_reg.f.treg_zero <= f2_reg.treg_zero;
            sba3_reg.f.cap       <= f2_reg.cap;
            sba3_reg.grid        <= grid2_reg;
        end
    end

    // divider group A: warps per block, max warps, shared and register limits
    logic [29:0] wpb_a;
    logic [6:0]  wpb_rem_a;
    logic [12:0] mw_a;
    logic [6:0]  mw_rem_a;
    logic [18:0] sl_a;
    logic [19:0] sl_rem_a;
    logic [16:0] rl_a;
    logic [17:0] rl_rem_a;
    gboc_pkg::sba_t sba_a;

    gboc_div #(.QW(30), .DW(7), .STAGES(LAT_A)) u_div_wpb (
        .aclk(aclk), .en(en), .acc_i({7'd0, wpbn3_reg}), .den_i(warp_width_reg),
        .quo_o(wpb_a), .rem_o(wpb_rem_a)
    );
    gboc_div #(.QW(13), .DW(7), .STAGES(LAT_A)) u_div_mw (
        .aclk(aclk), .en(en), .acc_i({7'd0, threads_sm_reg}), .den_i(warp_width_reg),
        .quo_o(mw_a), .rem_o(mw_rem_a)
    );
    gboc_div #(.QW(19), .DW(20), .STAGES(LAT_A)) u_div_sl (
        .aclk(aclk), .en(en), .acc_i({20'd0, shared_sm_reg}), .den_i(smem3_reg),
        .quo_o(sl_a), .rem_o(sl_rem_a)
    );
    gboc_div #(.QW(17), .DW(18), .STAGES(LAT_A)) u_div_rl (
        .aclk(aclk), .en(en), .acc_i({18'd0, regs_sm_reg}), .den_i(rt3_reg),
        .quo_o(rl_a), .rem_o(rl_rem_a)
    );
    gboc_dly #(.W($bits(gboc_pkg::sba_t)), .D(LAT_A)) u_dly_a (
        .aclk(aclk), .en(en), .d_i(sba3_reg), .q_o(sba_a)
    );

    // divider group B: warp limit
    logic [13:0] wpb_clip;
    logic [12:0] wl_b;
    logic [13:0] wl_rem_b;
    gboc_pkg::sbb_t sbb_in;
    gboc_pkg::sbb_t sbb_b;

    // a block wider than 2^13 warps never fits
    assign wpb_clip = (|wpb_a[29:13]) ? 14'h2000 : wpb_a[13:0];

    always_comb begin
        sbb_in.f      = sba_a.f;
        sbb_in.grid   = sba_a.grid;
        sbb_in.wpb    = wpb_a;
        sbb_in.mw     = mw_a;
        sbb_in.sl_raw = sl_a;
        sbb_in.rl_raw = rl_a;
    end

    gboc_div #(.QW(13), .DW(14), .STAGES(LAT_B)) u_div_wl (
        .aclk(aclk), .en(en), .acc_i({14'd0, mw_a}), .den_i(wpb_clip),
        .quo_o(wl_b), .rem_o(wl_rem_b)
    );
    gboc_dly #(.W($bits(gboc_pkg::sbb_t)), .D(LAT_B)) u_dly_b (
        .aclk(aclk), .en(en), .d_i(sbb_in), .q_o(sbb_b)
    );

    // stage M: resolve the unconstrained cases and take the minimum
    gboc_pkg::sbm_t sbm_next;
    gboc_pkg::sbm_t sbm_reg;

    always_comb begin
        logic [18:0] m;
        sbm_next.f    = sbb_b.f;
        sbm_next.grid = sbb_b.grid;
        sbm_next.wpb  = sbb_b.wpb;
        sbm_next.mw   = sbb_b.mw;
        sbm_next.wl   = wl_b;
        sbm_next.rl   = sbb_b.f.treg_zero ? 17'(sbb_b.f.cap) : sbb_b.rl_raw;
        sbm_next.sl   = sbb_b.f.smem_zero ? 19'(sbb_b.f.cap) : sbb_b.sl_raw;
        m = 19'(sbb_b.f.cap);
        if (19'(sbm_next.wl) < m) m = 19'(sbm_next.wl);
        if (19'(sbm_next.rl) < m) m = 19'(sbm_next.rl);
        if (sbm_next.sl < m)      m = sbm_next.sl;
        // resident floor: one block always runs
        sbm_next.blocks = (m == 19'd0) ? 6'd1 : m[5:0];
    end

    // stages N, O, P: occupancy numerator and saturation test
    gboc_pkg::sbm_t sbn_reg;
    gboc_pkg::sbm_t sbp_reg;
    logic [20:0] kb_reg;
    logic [50:0] onum_reg;
    logic        sat_reg;
    logic [28:0] oacc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sbm_reg  <= sbm_next;
            sbn_reg  <= sbm_reg;
            kb_reg   <= 21'(sbm_reg.blocks) * gboc_pkg::OCC_SCALE;
            sbp_reg  <= sbn_reg;
            onum_reg <= 51'(kb_reg) * 51'(sbn_reg.wpb);
        end
    end

    gboc_pkg::sbm_t sbq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sbq_reg  <= sbp_reg;
            // zero max warps also lands here
            sat_reg  <= onum_reg >= {22'd0, sbp_reg.mw, 16'd0};
            oacc_reg <= onum_reg[28:0];
        end
    end

    // divider group C: occupancy and waves
    gboc_pkg::sbc_t sbc_in;
    gboc_pkg::sbc_t sbc_c;
    logic [15:0] occ_c;
    logic [12:0] occ_rem_c;
    logic [62:0] wq_c;
    logic [5:0]  wrem_c;

    always_comb begin
        sbc_in.f      = sbq_reg.f;
        sbc_in.wl     = sbq_reg.wl;
        sbc_in.rl     = sbq_reg.rl;
        sbc_in.sl     = sbq_reg.sl;
        sbc_in.blocks = sbq_reg.blocks;
        sbc_in.sat    = sat_reg;
    end

    gboc_div #(.QW(16), .DW(13), .STAGES(LAT_C)) u_div_occ (
        .aclk(aclk), .en(en), .acc_i(oacc_reg), .den_i(sbq_reg.mw),
        .quo_o(occ_c), .rem_o(occ_rem_c)
    );
    gboc_div #(.QW(63), .DW(6), .STAGES(LAT_C)) u_div_wave (
        .aclk(aclk), .en(en), .acc_i({6'd0, sbq_reg.grid}), .den_i(sbq_reg.blocks),
        .quo_o(wq_c), .rem_o(wrem_c)
    );
    gboc_dly #(.W($bits(gboc_pkg::sbc_t)), .D(LAT_C)) u_dly_c (
        .aclk(aclk), .en(en), .d_i(sbc_in), .q_o(sbc_c)
    );

    // divider group D: fraction of the last wave
    gboc_pkg::sbd_t sbd_in;
    gboc_pkg::sbd_t sbd_d;
    logic [7:0] frac_d;
    logic [5:0] frac_rem_d;

    always_comb begin
        sbd_in.c     = sbc_c;
        sbd_in.occ   = occ_c;
        sbd_in.waves = wq_c + 63'(wrem_c != 6'd0);
    end

    gboc_div #(.QW(8), .DW(6), .STAGES(LAT_D)) u_div_frac (
        .aclk(aclk), .en(en), .acc_i({wrem_c, 8'd0}), .den_i(sbc_c.blocks),
        .quo_o(frac_d), .rem_o(frac_rem_d)
    );
    gboc_dly #(.W($bits(gboc_pkg::sbd_t)), .D(LAT_D)) u_dly_d (
        .aclk(aclk), .en(en), .d_i(sbd_in), .q_o(sbd_d)
    );

    // output register: zero the fields that the early-out cases drop
    logic ok;
    assign ok = !sbd_d.c.f.empty && !sbd_d.c.f.ovf;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_valid_res        <= ok;
            m_arch_block_cap   <= sbd_d.c.f.cap;
            m_warp_limit       <= sbd_d.c.f.empty ? 13'd0 : sbd_d.c.wl;
            m_register_limit   <= sbd_d.c.f.empty ? 14'd0 : sbd_d.c.rl[13:0];
            m_shared_limit     <= ok ? sbd_d.c.sl : 19'd0;
            m_blocks_per_sm    <= ok ? sbd_d.c.blocks : 6'd0;
            m_occupancy_q8     <= !ok ? 16'd0 :
                                  (sbd_d.c.sat ? gboc_pkg::OCC_SAT : sbd_d.occ);
            m_waves_rounded_up <= ok ? sbd_d.waves : 63'd0;
            m_wave_fraction_q8 <= ok ? frac_d : 8'd0;
        end
    end

endmodule

@@ hw/rtl/gboc_chk.sv @@
// Port-level checks on the result channel.
module gboc_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_valid_res,
    input logic [5:0]  m_arch_block_cap,
    input logic [5:0]  m_blocks_per_sm,
    input logic [15:0] m_occupancy_q8,
    input logic [62:0] m_waves_rounded_up,
    input logic [7:0]  m_wave_fraction_q8
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blocks_per_sm)
            && $stable(m_waves_rounded_up) && $stable(m_occupancy_q8))
        else $error("result beat changed while stalled");

    // resident count lies between one and the cap
    a_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_res |-> m_blocks_per_sm != 6'd0
            && m_blocks_per_sm <= m_arch_block_cap)
        else $error("blocks per SM out of range");

    // rejected launches carry no occupancy or waves
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_blocks_per_sm == 6'd0
            && m_occupancy_q8 == 16'd0 && m_waves_rounded_up == 63'd0)
        else $error("rejected launch has nonzero results");

    // a partial wave implies at least one wave
    a_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wave_fraction_q8 != 8'd0 |-> m_waves_rounded_up != 63'd0)
        else $error("wave fraction without waves");

endmodule

bind gpu_block_occupancy_calc gboc_chk u_gboc_chk (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_valid_res(m_valid_res),
    .m_arch_block_cap(m_arch_block_cap),
    .m_blocks_per_sm(m_blocks_per_sm),
    .m_occupancy_q8(m_occupancy_q8),
    .m_waves_rounded_up(m_waves_rounded_up),
    .m_wave_fraction_q8(m_wave_fraction_q8)
);

@@ verif/tb_gpu_block_occupancy_calc.sv @@
module tb_gpu_block_occupancy_calc;

    typedef struct {
        logic [10:0] bx;
        logic [10:0] by;
        logic [6:0]  bz;
        logic [30:0] gx;
        logic [15:0] gy;
        logic [15:0] gz;
        logic [7:0]  treg;
        logic [18:0] sstat;
        logic [18:0] sdyn;
    } launch_t;

    typedef struct {
        logic        ok;
        logic [5:0]  cap;
        logic [12:0] wl;
        logic [13:0] rl;
        logic [18:0] sl;
        logic [5:0]  blocks;
        logic [15:0] occ;
        logic [62:0] waves;
        logic [7:0]  frac;
    } occ_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [gboc_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [gboc_pkg::CFG_DW-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [10:0] s_block_x = '0;
    logic [10:0] s_block_y = '0;
    logic [6:0]  s_block_z = '0;
    logic [30:0] s_grid_x = '0;
    logic [15:0] s_grid_y = '0;
    logic [15:0] s_grid_z = '0;
    logic [7:0]  s_thread_registers = '0;
    logic [18:0] s_static_shared = '0;
    logic [18:0] s_dynamic_shared = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic        m_valid_res;
    logic [5:0]  m_arch_block_cap;
    logic [12:0] m_warp_limit;
    logic [13:0] m_register_limit;
    logic [18:0] m_shared_limit;
    logic [5:0]  m_blocks_per_sm;
    logic [15:0] m_occupancy_q8;
    logic [62:0] m_waves_rounded_up;
    logic [7:0]  m_wave_fraction_q8;

    gpu_block_occupancy_calc uut (.*);

    always #5 aclk = ~aclk;

    // device settings as the predictor sees them
    logic [3:0]  dev_major = gboc_pkg::RST_ARCH_MAJOR;
    logic [3:0]  dev_minor = gboc_pkg::RST_ARCH_MINOR;
    logic [6:0]  dev_warp = gboc_pkg::RST_WARP_WIDTH;
    logic [12:0] dev_threads = gboc_pkg::RST_THREADS_SM;
    logic [16:0] dev_regs = gboc_pkg::RST_REGS_SM;
    logic [18:0] dev_shared = gboc_pkg::RST_SHARED_SM;
    logic [18:0] dev_optin = gboc_pkg::RST_SHARED_OPTIN;

    launch_t  pending_launches[$];
    occ_res_t expected_results[$];
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 81;
    int unsigned hold_cycles = 0;
    int unsigned err_count = 0;
    bit in_beat = 1'b0;

    function automatic occ_res_t predict_occupancy(launch_t l);
        occ_res_t r;
        longint unsigned cap, threads, wpb, maxw, wl, rl, sl, smem, blk, occ, grid, rnd;
        r = '{default: '0};
        if (dev_major >= gboc_pkg::MAJOR_NEW) cap = gboc_pkg::CAP_HI;
        else if (dev_major == gboc_pkg::MAJOR_MID && dev_minor >= gboc_pkg::MINOR_SPLIT)
            cap = gboc_pkg::CAP_LO;
        else if (dev_major == gboc_pkg::MAJOR_MID || dev_major == gboc_pkg::MAJOR_OLD)
            cap = gboc_pkg::CAP_HI;
        else cap = gboc_pkg::CAP_LO;
        r.cap = 6'(cap);
        threads = longint'(l.bx) * l.by * l.bz;
        if (threads == 0 || dev_warp == 0) return r;
        wpb = (threads + dev_warp - 1) / dev_warp;
        maxw = dev_threads / dev_warp;
        wl = maxw / wpb;
        if (l.treg != 0) begin
            rnd = ((longint'(l.treg) + 7) / 8) * 8;
            rl = dev_regs / (rnd * threads);
        end else begin
            rl = cap;
        end
        r.wl = 13'(wl);
        r.rl = 14'(rl);
        // opt-in overflow keeps only the cap and the warp and register limits
        if (l.sdyn > dev_optin) return r;
        smem = longint'(l.sstat) + l.sdyn;
        sl = (smem != 0) ? dev_shared / smem : cap;
        blk = wl;
        if (rl < blk) blk = rl;
        if (sl < blk) blk = sl;
        if (cap < blk) blk = cap;
        if (blk < 1) blk = 1;
        if (maxw == 0) occ = 65535;
        else begin
            occ = (25600 * blk * wpb) / maxw;
            if (occ > 65535) occ = 65535;
        end
        grid = longint'(l.gx) * l.gy * l.gz;
        r.ok = 1'b1;
        r.sl = 19'(sl);
        r.blocks = 6'(blk);
        r.occ = 16'(occ);
        r.waves = 63'(grid / blk + ((grid % blk != 0) ? 1 : 0));
        r.frac = 8'(((grid % blk) * 256) / blk);
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // input and result beats, checked at the rising edge
    always @(posedge aclk) begin
        occ_res_t e;
        in_beat = aresetn && s_valid && s_ready;
        if (in_beat)
            expected_results.push_back(predict_occupancy('{s_block_x, s_block_y, s_block_z,
                s_grid_x, s_grid_y, s_grid_z, s_thread_registers, s_static_shared,
                s_dynamic_shared}));
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                err_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("valid_res", e.ok, m_valid_res);
                check_field("arch_block_cap", e.cap, m_arch_block_cap);
                check_field("warp_limit", e.wl, m_warp_limit);
                check_field("register_limit", e.rl, m_register_limit);
                check_field("shared_limit", e.sl, m_shared_limit);
                check_field("blocks_per_sm", e.blocks, m_blocks_per_sm);
                check_field("occupancy_q8", e.occ, m_occupancy_q8);
                check_field("waves_rounded_up", e.waves, m_waves_rounded_up);
                check_field("wave_fraction_q8", e.frac, m_wave_fraction_q8);
            end
        end
    end

    // launch driver
    always @(negedge aclk) begin
        launch_t l;
        if (aresetn && (!s_valid || in_beat)) begin
            if (pending_launches.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                l = pending_launches.pop_front();
                s_block_x <= l.bx;
                s_block_y <= l.by;
                s_block_z <= l.bz;
                s_grid_x <= l.gx;
                s_grid_y <= l.gy;
                s_grid_z <= l.gz;
                s_thread_registers <= l.treg;
                s_static_shared <= l.sstat;
                s_dynamic_shared <= l.sdyn;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [gboc_pkg::CFG_AW-1:0] idx,
                             logic [gboc_pkg::CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        case (idx)
            gboc_pkg::REG_ARCH_MAJOR:   dev_major = val[3:0];
            gboc_pkg::REG_ARCH_MINOR:   dev_minor = val[3:0];
            gboc_pkg::REG_WARP_WIDTH:   dev_warp = val[6:0];
            gboc_pkg::REG_THREADS_SM:   dev_threads = val[12:0];
            gboc_pkg::REG_REGS_SM:      dev_regs = val[16:0];
            gboc_pkg::REG_SHARED_SM:    dev_shared = val[18:0];
            gboc_pkg::REG_SHARED_OPTIN: dev_optin = val[18:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_device(int mj, int mn, int w, int t, int rg, int sh, int op);
        write_reg(gboc_pkg::REG_ARCH_MAJOR, 19'(mj));
        write_reg(gboc_pkg::REG_ARCH_MINOR, 19'(mn));
        write_reg(gboc_pkg::REG_WARP_WIDTH, 19'(w));
        write_reg(gboc_pkg::REG_THREADS_SM, 19'(t));
        write_reg(gboc_pkg::REG_REGS_SM, 19'(rg));
        write_reg(gboc_pkg::REG_SHARED_SM, 19'(sh));
        write_reg(gboc_pkg::REG_SHARED_OPTIN, 19'(op));
    endtask

    function automatic launch_t random_launch();
        launch_t l;
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0) begin
            // raw noise over the full field widths
            l = '{11'($urandom), 11'($urandom), 7'($urandom), 31'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom), 19'($urandom),
                  19'($urandom)};
        end else begin
            l.bx = 11'd1 << $urandom_range(10);
            l.by = 11'($urandom_range(1, 1024) >> $urandom_range(10));
            l.bz = 7'($urandom_range(0, 64) >> $urandom_range(6));
            if (l.by == 0) l.by = 1;
            if (l.bz == 0 && sel != 1) l.bz = 1;
            l.bx = 11'(l.bx - $urandom_range(l.bx - 1));
            l.gx = 31'($urandom >> $urandom_range(31));
            l.gy = 16'($urandom >> $urandom_range(16));
            l.gz = 16'($urandom >> $urandom_range(16));
            l.treg = 8'($urandom_range(255));
            l.sstat = 19'($urandom >> $urandom_range(13, 19));
            l.sdyn = (sel == 2) ? 19'($urandom_range(dev_optin, 19'h7FFFF))
                                : 19'(($urandom >> $urandom_range(13, 19))
                                      % (dev_optin + 1));
        end
        return l;
    endfunction

    task automatic drain();
        while (pending_launches.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed launches on the reset device, with a long receiver hold-off
        pending_launches.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        pending_launches.push_back('{1, 1, 1, 1, 1, 1, 0, 0, 0});
        pending_launches.push_back('{1024, 1, 1, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 255,
                                     0, 166912});
        pending_launches.push_back('{2047, 2047, 127, 31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 255,
                                     19'h7FFFF, 19'h7FFFF});
        pending_launches.push_back('{32, 8, 1, 1000, 3, 7, 32, 1024, 2048});
        pending_launches.push_back('{128, 1, 1, 0, 5, 5, 40, 0, 0});
        pending_launches.push_back('{64, 2, 0, 9, 9, 9, 16, 100, 100});
        pending_launches.push_back('{256, 1, 1, 77, 1, 1, 64, 4096, 166913});
        pending_launches.push_back('{16, 16, 4, 1, 1, 1, 255, 262144, 0});
        pending_launches.push_back('{1, 1, 64, 31'h40000000, 1, 1, 1, 1, 1});
        pending_launches.push_back('{33, 1, 1, 17, 3, 1, 9, 0, 20000});
        pending_launches.push_back('{1024, 1024, 64, 5, 1, 1, 8, 0, 0});
        repeat (40) pending_launches.push_back(random_launch());
        hold_cycles = 300;
        drain();

        for (phase = 0; phase < 11; phase++) begin
            case (phase)
                0: set_device(9, 0, 32, 2048, 65536, 233472, 232448);
                1: set_device(8, 6, 32, 1536, 65536, 102400, 101376);
                2: set_device(7, 5, 32, 1024, 65536, 65536, 65536);
                3: set_device(0, 15, 1, 64, 0, 0, 0);
                4: set_device(15, 15, 64, 4096, 65536, 262144, 262144);
                5: set_device(3, 0, 0, 2048, 65536, 49152, 49152);
                6: set_device(6, 1, 64, 16, 32768, 98304, 1024);
                7: set_device(8, 9, 127, 8191, 17'h1FFFF, 19'h7FFFF, 19'h7FFFF);
                default: set_device($urandom_range(15), $urandom_range(15),
                                    $urandom_range(1, 64), $urandom_range(64, 4096),
                                    $urandom_range(65536), $urandom_range(262144),
                                    $urandom_range(262144));
            endcase
            // idling: sender light first, then receiver light, then none
            if (phase < 4) begin
                send_idle_pct = 15;
                recv_idle_pct = 81;
            end else if (phase < 8) begin
                send_idle_pct = 81;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (50) pending_launches.push_back(random_launch());
            drain();
        end

        if (err_count == 0) begin
            $display("gpu_block_occupancy_calc verification clean");
        end else begin
            $display("gpu_block_occupancy_calc verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("gpu_block_occupancy_calc verification failed");
        $finish;
    end
endmodule
